>>> sv/bpc_pkg.sv
// shared types and constants for the barometric compensation pipeline
`default_nettype none
package bpc_pkg;

  localparam int PIPE_DEPTH = 9;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int OUT_W   = 20;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [19:0] TEMP_REF_CENTI = 20'sd2000;
  localparam logic signed [19:0] TEMP_LOW_CENTI = -20'sd1500;
  localparam logic [19:0]        PRESS_MAX      = 20'hFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS          = 3'd0,
    REG_OFFSET        = 3'd1,
    REG_SENS_TEMPCO   = 3'd2,
    REG_OFFSET_TEMPCO = 3'd3,
    REG_REF_TEMP      = 3'd4,
    REG_TEMP_SLOPE    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] en;
    logic [PIPE_DEPTH-1:0] vld;
  } pipe_ctl_t;

endpackage
`default_nettype wire

>>> sv/bpc_pipe_ctrl.sv
// per-stage valid bits and load enables for the compensation pipeline
`default_nettype none
module bpc_pipe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              out_ready,
  output logic                   in_ready,
  output bpc_pkg::pipe_ctl_t     ctl
);
  import bpc_pkg::*;

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] en;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || out_ready;
    for (int k = PIPE_DEPTH-2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign ctl.en   = en;
  assign ctl.vld  = vld;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    vld[PIPE_DEPTH/2] && !en[PIPE_DEPTH/2] |=> vld[PIPE_DEPTH/2])
    else $error("stalled stage lost its transaction");

  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    vld[PIPE_DEPTH-1] && !out_ready |-> !en[0] || !vld[0] || !en[PIPE_DEPTH-1])
    else $error("last stage loaded while output stalled");

endmodule
`default_nettype wire

>>> sv/baro_pressure_temp_compensation.sv
// top level: second-order barometric pressure and temperature compensation
// an input transaction passes through stages 0 to 8; stage 8 is the output register
// throughput: one reading pair per cycle while out_ready holds, set by the nine-stage multiplier pipeline
// a stalled output holds the last stage; earlier empty stages keep accepting
// reset clears all valid bits and the six calibration registers to zero
`default_nettype none
module baro_pressure_temp_compensation (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bpc_pkg::COEF_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bpc_pkg::RAW_W-1:0]     raw_pressure,
  input  wire logic [bpc_pkg::RAW_W-1:0]     raw_temperature,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [bpc_pkg::OUT_W-1:0]   temperature_centi,
  output logic [bpc_pkg::OUT_W-1:0]          pressure_pa,
  output logic                               pressure_clamped
);
  import bpc_pkg::*;

  pipe_ctl_t ctl;

  logic [15:0] c_sens, c_offset, c_sens_tc, c_offset_tc, c_ref_temp, c_temp_slope;

  // calibration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_sens       <= '0;
      c_offset     <= '0;
      c_sens_tc    <= '0;
      c_offset_tc  <= '0;
      c_ref_temp   <= '0;
      c_temp_slope <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENS:          c_sens       <= cfg_data;
        REG_OFFSET:        c_offset     <= cfg_data;
        REG_SENS_TEMPCO:   c_sens_tc    <= cfg_data;
        REG_OFFSET_TEMPCO: c_offset_tc  <= cfg_data;
        REG_REF_TEMP:      c_ref_temp   <= cfg_data;
        REG_TEMP_SLOPE:    c_temp_slope <= cfg_data;
        default: ;
      endcase
    end
  end

  bpc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  // stage 0: temperature difference
  logic [23:0]        s0_d1;
  logic signed [24:0] s0_dt;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s0_d1 <= raw_pressure;
      s0_dt <= $signed({1'b0, raw_temperature}) - $signed({1'b0, c_ref_temp, 8'h00});
    end
  end

  // stage 1: coefficient products and dT squared
  logic [23:0]        s1_d1;
  logic signed [41:0] s1_m6, s1_m4, s1_m3;
  logic [17:0]        s1_t2;
  logic signed [49:0] dt_sq;

  assign dt_sq = s0_dt * s0_dt;

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s1_d1 <= s0_d1;
      s1_m6 <= $signed({1'b0, c_temp_slope}) * s0_dt;
      s1_m4 <= $signed({1'b0, c_offset_tc}) * s0_dt;
      s1_m3 <= $signed({1'b0, c_sens_tc}) * s0_dt;
      s1_t2 <= dt_sq[48:31];
    end
  end

  // stage 2: first-order temperature, offset and sensitivity
  logic [23:0]        s2_d1;
  logic signed [19:0] s2_temp;
  logic signed [41:0] s2_off, s2_sens;
  logic [17:0]        s2_t2;
  logic signed [41:0] m6_sh;

  assign m6_sh = s1_m6 >>> 23;

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s2_d1   <= s1_d1;
      s2_temp <= m6_sh[19:0] + TEMP_REF_CENTI;
      s2_off  <= $signed({10'b0, c_offset, 16'b0}) + (s1_m4 >>> 7);
      s2_sens <= $signed({11'b0, c_sens, 15'b0}) + (s1_m3 >>> 8);
      s2_t2   <= s1_t2;
    end
  end

  // stage 3: squared distances from the correction thresholds
  logic [23:0]        s3_d1;
  logic signed [19:0] s3_temp;
  logic signed [41:0] s3_off, s3_sens;
  logic [17:0]        s3_t2;
  logic [39:0]        s3_dd_sq, s3_dl_sq;
  logic               s3_low, s3_vlow;
  logic signed [20:0] dd, dl;
  logic signed [41:0] dd_sq, dl_sq;

  assign dd    = 21'(s2_temp) - 21'(TEMP_REF_CENTI);
  assign dl    = 21'(s2_temp) - 21'(TEMP_LOW_CENTI);
  assign dd_sq = dd * dd;
  assign dl_sq = dl * dl;

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s3_d1    <= s2_d1;
      s3_temp  <= s2_temp;
      s3_off   <= s2_off;
      s3_sens  <= s2_sens;
      s3_t2    <= s2_t2;
      s3_dd_sq <= dd_sq[39:0];
      s3_dl_sq <= dl_sq[39:0];
      s3_low   <= s2_temp < TEMP_REF_CENTI;
      s3_vlow  <= s2_temp < TEMP_LOW_CENTI;
    end
  end

  // stage 4: second-order correction terms
  logic [23:0]        s4_d1;
  logic signed [19:0] s4_temp;
  logic signed [41:0] s4_off, s4_sens;
  logic [17:0]        s4_t2;
  logic [41:0]        s4_off2, s4_sens2;
  logic [41:0]        sq5, lsq7, lsq11, off2, sens2;

  assign sq5   = ({2'b0, s3_dd_sq} << 2) + {2'b0, s3_dd_sq};
  assign lsq7  = ({2'b0, s3_dl_sq} << 3) - {2'b0, s3_dl_sq};
  assign lsq11 = ({2'b0, s3_dl_sq} << 3) + ({2'b0, s3_dl_sq} << 1) + {2'b0, s3_dl_sq};
  assign off2  = (sq5 >> 1) + (s3_vlow ? lsq7 : 42'd0);
  assign sens2 = (sq5 >> 2) + (s3_vlow ? (lsq11 >> 1) : 42'd0);

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      s4_d1    <= s3_d1;
      s4_temp  <= s3_temp;
      s4_off   <= s3_off;
      s4_sens  <= s3_sens;
      s4_t2    <= s3_low ? s3_t2 : 18'd0;
      s4_off2  <= s3_low ? off2 : 42'd0;
      s4_sens2 <= s3_low ? sens2 : 42'd0;
    end
  end

  // stage 5: corrected temperature, offset and sensitivity
  logic [23:0]        s5_d1;
  logic signed [19:0] s5_temp;
  logic signed [41:0] s5_off, s5_sens;

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      s5_d1   <= s4_d1;
      s5_temp <= s4_temp - $signed({2'b0, s4_t2});
      s5_off  <= s4_off - $signed(s4_off2);
      s5_sens <= s4_sens - $signed(s4_sens2);
    end
  end

  // stage 6: d1 times sensitivity, split into high and low halves
  logic signed [19:0] s6_temp;
  logic signed [41:0] s6_off;
  logic signed [45:0] s6_ph;
  logic [44:0]        s6_pl;
  logic signed [20:0] sens_hi;
  logic [20:0]        sens_lo;

  assign sens_hi = s5_sens[41:21];
  assign sens_lo = s5_sens[20:0];

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      s6_temp <= s5_temp;
      s6_off  <= s5_off;
      s6_ph   <= $signed({1'b0, s5_d1}) * sens_hi;
      s6_pl   <= s5_d1 * sens_lo;
    end
  end

  // stage 7: (d1*sens >> 21) - off
  logic signed [19:0] s7_temp;
  logic signed [46:0] s7_q;

  always_ff @(posedge clk) begin
    if (ctl.en[7]) begin
      s7_temp <= s6_temp;
      s7_q    <= 47'(s6_ph) + $signed({23'b0, s6_pl[44:21]}) - 47'(s6_off);
    end
  end

  // stage 8: scale to pascals and clamp, output register
  logic q_neg, q_over;

  assign q_neg  = s7_q[46];
  assign q_over = !q_neg && (|s7_q[46:35]);

  always_ff @(posedge clk) begin
    if (ctl.en[8]) begin
      temperature_centi <= s7_temp;
      pressure_clamped  <= q_neg || q_over;
      if (q_neg) begin
        pressure_pa <= '0;
      end else if (q_over) begin
        pressure_pa <= PRESS_MAX;
      end else begin
        pressure_pa <= s7_q[34:15];
      end
    end
  end

  assign out_valid = ctl.vld[PIPE_DEPTH-1];

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressure_clamped |-> pressure_pa == '0 || pressure_pa == PRESS_MAX)
    else $error("clamped pressure not at a range limit");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ctl.vld[0])
    else $error("accepted transaction missing from first stage");

  a_second_order_gate: assert property (@(posedge clk) disable iff (rst)
    ctl.vld[4] && $past(ctl.en[4]) && $past(!s3_low) |-> s4_off2 == '0 && s4_t2 == '0)
    else $error("second-order terms applied above reference temperature");

endmodule
`default_nettype wire
